FILE: design/kmfq_pkg.sv
// shared types, sizes and codes for the keyed multi-queue block
// no dependencies; imported by every module of the block
package kmfq_pkg;

  // table and queue sizes
  localparam int NUM_OWNERS  = 16;
  localparam int QUEUE_DEPTH = 8;

  // derived widths
  localparam int SLOT_W  = $clog2(NUM_OWNERS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_OWNERS * QUEUE_DEPTH);

  // fixed field widths of the request and result
  localparam int OPC_W   = 2;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 31;
  localparam int STAT_W  = 3;
  localparam int QCNT_W  = 4;
  localparam int SIDX_W  = 4;

  // depth of the command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  // opcodes
  localparam logic [OPC_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OPC_W-1:0] OP_ENQUEUE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_DEQUEUE  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd4;

  // request payload
  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] owner_key;
    logic [VAL_W-1:0] entry_value;
  } kmfq_in_t;

  // result payload
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  head_value;
    logic [QCNT_W-1:0] queue_count;
    logic [SIDX_W-1:0] slot_index;
  } kmfq_out_t;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    KIND_REPORT,
    KIND_CLAIM,
    KIND_PUSH,
    KIND_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  value;
  } kmfq_cmd_t;

endpackage

FILE: design/kmfq_front.sv
// front end: owner key table, associative match and request classification
// depends on kmfq_pkg
module kmfq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  kmfq_pkg::kmfq_in_t in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output kmfq_pkg::kmfq_cmd_t q_cmd
);
  import kmfq_pkg::*;

  logic [KEY_W-1:0]      key_r [NUM_OWNERS];
  logic [KEY_W-1:0]      search_key;
  logic [NUM_OWNERS-1:0] hit;
  logic                  hit_any;
  logic [SLOT_W-1:0]     hit_slot;

  // match against the table; a register request looks for a free slot
  always_comb begin
    search_key = (in_data.opcode == OP_REGISTER) ? '0 : in_data.owner_key;
    for (int i = 0; i < NUM_OWNERS; i++) begin
      hit[i] = (key_r[i] == search_key);
    end
    hit_any  = |hit;
    hit_slot = '0;
    for (int i = NUM_OWNERS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // classify the request
  always_comb begin
    q_cmd.kind   = KIND_REPORT;
    q_cmd.status = ST_NOT_FOUND;
    q_cmd.slot   = hit_slot;
    q_cmd.value  = in_data.entry_value;
    if (in_data.owner_key != '0) begin
      case (in_data.opcode)
        OP_REGISTER: begin
          if (hit_any) q_cmd.kind = KIND_CLAIM;
          else         q_cmd.status = ST_NO_FREE;
        end
        OP_ENQUEUE: begin
          if (hit_any) q_cmd.kind = KIND_PUSH;
        end
        OP_DEQUEUE: begin
          if (hit_any) q_cmd.kind = KIND_POP;
        end
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // claim the slot at accept time so later requests see the new owner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OWNERS; i++) begin
        key_r[i] <= '0;
      end
    end else if (q_push && q_cmd.kind == KIND_CLAIM) begin
      key_r[q_cmd.slot] <= in_data.owner_key;
    end
  end

endmodule

FILE: design/kmfq_cmd_queue.sv
// short command queue that decouples the front end from the back end
// depends on kmfq_pkg
module kmfq_cmd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kmfq_pkg::kmfq_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output kmfq_pkg::kmfq_cmd_t pop_cmd,
  output logic                not_empty
);
  import kmfq_pkg::*;

  kmfq_cmd_t            cmd_r [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CQ_CNT_W'(CMDQ_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = cmd_r[rd_ptr_r];

  // pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/kmfq_back.sv
// back end: per-queue pointers and counts, entry memory, result register
// depends on kmfq_pkg
module kmfq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  kmfq_pkg::kmfq_cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output kmfq_pkg::kmfq_out_t out_data
);
  import kmfq_pkg::*;

  // per-queue state
  logic [CNT_W-1:0] cnt_r [NUM_OWNERS];
  logic [PTR_W-1:0] rp_r  [NUM_OWNERS];
  logic [PTR_W-1:0] wp_r  [NUM_OWNERS];

  // entry memory
  logic [VAL_W-1:0] mem [NUM_OWNERS * QUEUE_DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  // execute stage and output register
  logic      x_valid_r, x_valid_nxt;
  kmfq_out_t x_res_r;
  logic      x_mem_r;
  logic      out_valid_r, out_valid_nxt;
  kmfq_out_t out_data_r;

  logic             exec, x_adv;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic [PTR_W-1:0] cur_rp, cur_wp, new_rp, new_wp;
  logic             upd, mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  kmfq_out_t        res;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // flow control
  assign x_adv   = x_valid_r && (!out_valid_r || !out_stall);
  assign exec    = cmd_valid && (!x_valid_r || x_adv);
  assign cmd_pop = exec;

  assign cur_cnt = cnt_r[cmd.slot];
  assign cur_rp  = rp_r[cmd.slot];
  assign cur_wp  = wp_r[cmd.slot];
  assign waddr   = ADDR_W'(cmd.slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_wp);
  assign raddr   = ADDR_W'(cmd.slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_rp);

  // command execution
  always_comb begin
    res.status      = cmd.status;
    res.head_value  = '0;
    res.queue_count = '0;
    res.slot_index  = '0;
    new_cnt = cur_cnt;
    new_rp  = cur_rp;
    new_wp  = cur_wp;
    upd     = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    case (cmd.kind)
      KIND_CLAIM: begin
        res.status     = ST_OK;
        res.slot_index = SIDX_W'(cmd.slot);
        new_cnt = '0;
        new_rp  = '0;
        new_wp  = '0;
        upd     = 1'b1;
      end
      KIND_PUSH: begin
        res.slot_index = SIDX_W'(cmd.slot);
        if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
          res.status      = ST_FULL;
          res.queue_count = QCNT_W'(cur_cnt);
        end else begin
          res.status      = ST_OK;
          new_cnt         = cur_cnt + 1'b1;
          new_wp          = ptr_inc(cur_wp);
          res.queue_count = QCNT_W'(new_cnt);
          upd             = 1'b1;
          mem_we          = 1'b1;
        end
      end
      KIND_POP: begin
        res.slot_index = SIDX_W'(cmd.slot);
        if (cur_cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status      = ST_OK;
          new_cnt         = cur_cnt - 1'b1;
          new_rp          = ptr_inc(cur_rp);
          res.queue_count = QCNT_W'(new_cnt);
          upd             = 1'b1;
          mem_re          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OWNERS; i++) begin
        cnt_r[i] <= '0;
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
      end
    end else if (exec && upd) begin
      cnt_r[cmd.slot] <= new_cnt;
      rp_r[cmd.slot]  <= new_rp;
      wp_r[cmd.slot]  <= new_wp;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      mem[waddr] <= cmd.value;
    end
    if (exec && mem_re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // execute stage and output register control
  always_comb begin
    x_valid_nxt = x_valid_r;
    if (exec) x_valid_nxt = 1'b1;
    else if (x_adv) x_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (x_adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (exec) begin
      x_res_r <= res;
      x_mem_r <= mem_re;
    end
    if (x_adv) begin
      out_data_r <= '{status:      x_res_r.status,
                      head_value:  x_mem_r ? rd_data_r : VAL_W'(0),
                      queue_count: x_res_r.queue_count,
                      slot_index:  x_res_r.slot_index};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/keyed_multi_fifo_queue_core.sv
// top level of the keyed multi-queue block: front end, command queue, back end
// depends on kmfq_pkg, kmfq_front, kmfq_cmd_queue, kmfq_back
//
// A table of 16 owner slots, each with an 8-entry circular queue. Every request
// (register, enqueue, dequeue) gives exactly one result, in request order. The
// front end matches the owner key against the key table in the accept cycle
// and claims slots there; a two-entry command queue feeds the back end, which
// updates the addressed queue's pointers and count and reads the head entry
// from the entry memory, whose read is registered. The block sustains one
// request per cycle while out_stall is low, set by the single-port
// read-modify-write of the per-queue pointers and the one access per cycle to
// the entry memory. A stalled result lets up to three more requests in before
// in_stall rises.
module keyed_multi_fifo_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kmfq_pkg::kmfq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kmfq_pkg::kmfq_out_t out_data
);
  import kmfq_pkg::*;

  logic      q_full, q_push, q_pop, q_not_empty;
  kmfq_cmd_t q_push_cmd, q_pop_cmd;

  // key match and classification
  kmfq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // decoupling queue
  kmfq_cmd_queue u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_not_empty)
  );

  // queue operations and result
  kmfq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_pop_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/kmfq_checker.sv
// port-level checks for the keyed multi-queue block, bound to the top level
// depends on kmfq_pkg and keyed_multi_fifo_queue_core
module kmfq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input kmfq_pkg::kmfq_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input kmfq_pkg::kmfq_out_t out_data
);
  import kmfq_pkg::*;

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // status is a defined code and the count stays within the depth
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_NO_FREE) &&
                  (out_data.queue_count <= QCNT_W'(QUEUE_DEPTH)))
    else $error("result status or count out of range");

  // only a successful dequeue returns a value
  a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.head_value == '0)
    else $error("value returned on a failed request");

  // unmatched and no-free results carry no slot or count
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_NO_FREE)
      |-> out_data.queue_count == '0 && out_data.slot_index == '0)
    else $error("miss result carries slot or count");

endmodule

bind keyed_multi_fifo_queue_core kmfq_checker u_kmfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
